### rtl/rrts_pkg.sv
// Shared types and constants for the round-robin thread scheduler.
// Used by rrts_ctrl, rrts_dpath and round_robin_thread_scheduler.
`default_nettype none
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int LEN_W       = $clog2(MAX_THREADS + 1);

    // command kinds
    localparam logic [3:0] K_START  = 4'd0;
    localparam logic [3:0] K_BOOT   = 4'd1;
    localparam logic [3:0] K_ATTACH = 4'd2;
    localparam logic [3:0] K_DETACH = 4'd3;
    localparam logic [3:0] K_SLEEP  = 4'd4;
    localparam logic [3:0] K_WAKE   = 4'd5;
    localparam logic [3:0] K_SETRUN = 4'd6;
    localparam logic [3:0] K_SWITCH = 4'd7;
    localparam logic [3:0] K_EXIT   = 4'd8;

    // result status codes
    localparam logic [1:0] RS_OK     = 2'd0;
    localparam logic [1:0] RS_FAIL   = 2'd1;
    localparam logic [1:0] RS_CANCEL = 2'd2;

    typedef enum logic [1:0] {
        ST_ABSENT = 2'd0,
        ST_READY  = 2'd1,
        ST_SLEEP  = 2'd2,
        ST_RUN    = 2'd3
    } slot_st_t;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_DROP_RUN,
        UOP_RUN_HEAD,
        UOP_RUN_T,
        UOP_SLEEP_T,
        UOP_ABSENT_T,
        UOP_REMOVE_T,
        UOP_PUSH_T,
        UOP_PUSH_RUN,
        UOP_SLEEP_RUN,
        UOP_WAKE_SET,
        UOP_WAKE_CLR,
        UOP_POP_NX,
        UOP_RUN_NX
    } uop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_EX2,
        S_EX3,
        S_RESP
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        uop_t uop;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] kind;
        slot_st_t   st_t;
        logic       t_ok;
        logic       asleep;
        logic       run_present;
        logic       run_is_t;
        logic       wp_run;
        logic       q_empty;
    } dp_stat_t;

endpackage
`default_nettype wire

### rtl/rrts_dpath.sv
// Datapath: slot state, wake flags, ready queue and running slot.
// Depends on rrts_pkg; executes one micro-op per cycle from rrts_ctrl.
`default_nettype none
module rrts_dpath
    import rrts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          cmd,
    input  wire logic [3:0]        kind,
    input  wire logic [ID_W-1:0]   thread_id,
    input  wire logic              attach_sleeping,
    output dp_stat_t               stat,
    output logic [ID_W-1:0]        running_id,
    output logic                   running_valid,
    output logic [4:0]             ready_count
);

    logic [3:0]       kind_reg;
    logic [ID_W-1:0]  tid_reg;
    logic             asleep_reg;
    logic [ID_W-1:0]  run_slot_reg, run_slot_next;
    logic             run_present_reg, run_present_next;
    logic [ID_W-1:0]  nx_reg, nx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    slot_st_t         st_reg [MAX_THREADS];
    logic             wp_reg [MAX_THREADS];
    logic [ID_W-1:0]  order_reg [MAX_THREADS];
    logic [ID_W-1:0]  order_next [MAX_THREADS];

    logic             st_we;
    logic [SLOT_W-1:0] st_addr;
    slot_st_t         st_data;
    logic             wp_we;
    logic [SLOT_W-1:0] wp_addr;
    logic             wp_data;

    logic             t_ok;
    logic [SLOT_W-1:0] t_slot, run_sl, head_sl;
    logic             q_full, q_empty;
    logic [MAX_THREADS-1:0] hit, shift_at;
    logic             hit_any;
    logic             do_push;
    logic [ID_W-1:0]  push_id;

    assign t_ok    = (32'(tid_reg) < MAX_THREADS);
    assign t_slot  = SLOT_W'(tid_reg);
    assign run_sl  = SLOT_W'(run_slot_reg);
    assign head_sl = SLOT_W'(order_reg[0]);
    assign q_empty = (len_reg == '0);
    assign q_full  = (32'(len_reg) >= MAX_THREADS);

    // position of tid in the queue, and everything at or above it
    always_comb
    begin
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            hit[i] = (order_reg[i] == tid_reg) && (32'(i) < 32'(len_reg));
        end
        shift_at[0] = hit[0];
        for (int i = 1; i < MAX_THREADS; i++)
        begin
            shift_at[i] = shift_at[i-1] | hit[i];
        end
        hit_any = |hit;
    end

    always_comb
    begin
        run_slot_next    = run_slot_reg;
        run_present_next = run_present_reg;
        nx_next          = nx_reg;
        len_next         = len_reg;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            order_next[i] = order_reg[i];
        end
        st_we   = 1'b0;
        st_addr = t_slot;
        st_data = ST_ABSENT;
        wp_we   = 1'b0;
        wp_addr = t_slot;
        wp_data = 1'b0;
        do_push = 1'b0;
        push_id = tid_reg;

        unique case (cmd.uop)
            UOP_DROP_RUN:
            begin
                st_we            = run_present_reg;
                st_addr          = run_sl;
                st_data          = ST_ABSENT;
                run_present_next = 1'b0;
                run_slot_next    = '0;
            end
            UOP_RUN_HEAD, UOP_POP_NX:
            begin
                if (!q_empty)
                begin
                    for (int i = 0; i < MAX_THREADS - 1; i++)
                    begin
                        order_next[i] = order_reg[i+1];
                    end
                    len_next = len_reg - 1'b1;
                    if (cmd.uop == UOP_RUN_HEAD)
                    begin
                        run_slot_next    = order_reg[0];
                        run_present_next = 1'b1;
                        st_we            = 1'b1;
                        st_addr          = head_sl;
                        st_data          = ST_RUN;
                    end
                    else
                    begin
                        nx_next = order_reg[0];
                    end
                end
                else if (cmd.uop == UOP_RUN_HEAD)
                begin
                    run_slot_next    = '0;
                    run_present_next = 1'b0;
                end
            end
            UOP_RUN_T:
            begin
                run_slot_next    = tid_reg;
                run_present_next = 1'b1;
                st_we            = 1'b1;
                st_data          = ST_RUN;
            end
            UOP_RUN_NX:
            begin
                run_slot_next    = nx_reg;
                run_present_next = 1'b1;
                st_we            = 1'b1;
                st_addr          = SLOT_W'(nx_reg);
                st_data          = ST_RUN;
            end
            UOP_SLEEP_T:
            begin
                st_we   = 1'b1;
                st_data = ST_SLEEP;
            end
            UOP_ABSENT_T:
            begin
                st_we   = 1'b1;
                st_data = ST_ABSENT;
            end
            UOP_REMOVE_T:
            begin
                for (int i = 0; i < MAX_THREADS - 1; i++)
                begin
                    if (shift_at[i])
                        order_next[i] = order_reg[i+1];
                end
                if (hit_any)
                    len_next = len_reg - 1'b1;
            end
            UOP_PUSH_T:
            begin
                do_push = 1'b1;
            end
            UOP_PUSH_RUN:
            begin
                do_push = run_present_reg;
                push_id = run_slot_reg;
            end
            UOP_SLEEP_RUN:
            begin
                st_we            = 1'b1;
                st_addr          = run_sl;
                st_data          = ST_SLEEP;
                run_present_next = 1'b0;
            end
            UOP_WAKE_SET:
            begin
                wp_we   = 1'b1;
                wp_data = 1'b1;
            end
            UOP_WAKE_CLR:
            begin
                wp_we   = 1'b1;
                wp_addr = run_sl;
                wp_data = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (do_push && !q_full)
        begin
            order_next[SLOT_W'(len_reg)] = push_id;
            len_next = len_reg + 1'b1;
            st_we    = 1'b1;
            st_addr  = SLOT_W'(push_id);
            st_data  = ST_READY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_slot_reg    <= '0;
            run_present_reg <= 1'b0;
            len_reg         <= '0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                st_reg[i] <= ST_ABSENT;
                wp_reg[i] <= 1'b0;
            end
        end
        else
        begin
            run_slot_reg    <= run_slot_next;
            run_present_reg <= run_present_next;
            len_reg         <= len_next;
            if (st_we)
                st_reg[st_addr] <= st_data;
            if (wp_we)
                wp_reg[wp_addr] <= wp_data;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        nx_reg <= nx_next;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            order_reg[i] <= order_next[i];
        end
        if (cmd.load)
        begin
            kind_reg   <= kind;
            tid_reg    <= thread_id;
            asleep_reg <= attach_sleeping;
        end
    end

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.st_t        = t_ok ? st_reg[t_slot] : ST_ABSENT;
        stat.t_ok        = t_ok;
        stat.asleep      = asleep_reg;
        stat.run_present = run_present_reg;
        stat.run_is_t    = (run_slot_reg == tid_reg);
        stat.wp_run      = wp_reg[run_sl];
        stat.q_empty     = q_empty;
    end

    assign running_id    = run_present_reg ? run_slot_reg : '0;
    assign running_valid = run_present_reg;
    assign ready_count   = 5'(len_reg);

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_THREADS)
        else $error("ready queue length beyond capacity");

    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.uop == UOP_RUN_HEAD && q_empty) |=> (!run_present_reg && run_slot_reg == '0))
        else $error("empty queue pop left a thread running");

    a_pop_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.uop == UOP_POP_NX && !q_empty) |=> (len_reg == $past(len_reg) - 1'b1))
        else $error("pop did not shorten queue");

endmodule
`default_nettype wire

### rtl/rrts_ctrl.sv
// Controller FSM: decodes a command into up to three micro-ops.
// Depends on rrts_pkg; drives rrts_dpath through ctl_cmd_t.
`default_nettype none
module rrts_ctrl
    import rrts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd,
    output logic          busy,
    output logic          done,
    output logic [1:0]    status
);

    ctl_state_t state_reg, state_next;
    uop_t       p1_reg, p1_next, p2_reg, p2_next;
    logic [1:0] rs_reg, rs_next;
    uop_t       d0, d1, d2;
    logic [1:0] drs;
    logic       accept;

    assign busy   = (state_reg != S_IDLE) && (state_reg != S_RESP);
    assign accept = start && !busy;

    // plan for the latched command
    always_comb
    begin
        d0  = UOP_NONE;
        d1  = UOP_NONE;
        d2  = UOP_NONE;
        drs = RS_OK;
        unique case (stat.kind)
            K_START:
            begin
                d0 = UOP_DROP_RUN;
                d1 = UOP_RUN_HEAD;
                if (stat.q_empty)
                    drs = RS_FAIL;
            end
            K_BOOT:
            begin
                if (stat.t_ok && stat.st_t == ST_ABSENT)
                begin
                    d0 = UOP_DROP_RUN;
                    d1 = UOP_RUN_T;
                end
            end
            K_ATTACH:
            begin
                if (stat.t_ok && stat.st_t == ST_ABSENT)
                    d0 = stat.asleep ? UOP_SLEEP_T : UOP_PUSH_T;
            end
            K_DETACH, K_EXIT:
            begin
                if (stat.kind == K_EXIT && stat.t_ok && stat.st_t == ST_RUN
                    && stat.run_present && stat.run_is_t)
                begin
                    d0 = UOP_ABSENT_T;
                    d1 = UOP_RUN_HEAD;
                end
                else if (stat.t_ok && stat.st_t == ST_SLEEP)
                begin
                    d0 = UOP_ABSENT_T;
                end
                else if (stat.t_ok && stat.st_t == ST_READY)
                begin
                    d0 = UOP_REMOVE_T;
                    d1 = UOP_ABSENT_T;
                end
            end
            K_SLEEP:
            begin
                if (stat.run_present)
                begin
                    if (stat.wp_run)
                    begin
                        d0  = UOP_WAKE_CLR;
                        drs = RS_CANCEL;
                    end
                    else
                    begin
                        d0 = UOP_SLEEP_RUN;
                        d1 = UOP_RUN_HEAD;
                    end
                end
            end
            K_WAKE:
            begin
                if (stat.t_ok)
                    d0 = (stat.st_t == ST_SLEEP) ? UOP_PUSH_T : UOP_WAKE_SET;
            end
            K_SETRUN:
            begin
                if (stat.t_ok && stat.st_t == ST_READY)
                begin
                    d0 = UOP_REMOVE_T;
                    d1 = UOP_PUSH_RUN;
                    d2 = UOP_RUN_T;
                end
            end
            K_SWITCH:
            begin
                if (stat.q_empty)
                begin
                    drs = RS_FAIL;
                end
                else
                begin
                    d0 = UOP_POP_NX;
                    d1 = UOP_PUSH_RUN;
                    d2 = UOP_RUN_NX;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p1_reg    <= UOP_NONE;
            p2_reg    <= UOP_NONE;
            rs_reg    <= RS_OK;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            rs_reg    <= rs_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        rs_next    = rs_reg;
        cmd.load   = accept;
        cmd.uop    = UOP_NONE;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.uop    = d0;
                p1_next    = d1;
                p2_next    = d2;
                rs_next    = drs;
                state_next = S_EX2;
            end
            S_EX2:
            begin
                cmd.uop    = p1_reg;
                state_next = S_EX3;
            end
            S_EX3:
            begin
                cmd.uop    = p2_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = accept ? S_DEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign status = rs_reg;

    a_dec_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEC |=> state_reg == S_EX2 ##1 state_reg == S_EX3
        ##1 state_reg == S_RESP)
        else $error("decode sequence broken");

    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DEC)
        else $error("accepted item not decoded");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_ex3_resp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EX3 |=> done)
        else $error("result not presented after last step");

endmodule
`default_nettype wire

### rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
`default_nettype none
// Usage:
//   A command item (kind, thread_id, attach_sleeping) is taken at a rising
//   edge with start high and busy low. Each item yields one result on
//   status, running_id, running_valid and ready_count, shown for exactly
//   one cycle with done high. The receiver cannot stall the block.
// Command sequence:
//   The result is shown after decode and two more steps, in the result
//   cycle, and is taken at the edge ending that cycle. Every command is
//   decoded into at most three queue/state steps run one per cycle in the
//   datapath, so a new item can be taken in the cycle its predecessor's
//   result is shown.
//   The ready queue is a register line; removal from the middle shifts all
//   later entries down in one step.
// Reset:
//   rst_n low clears the running slot, empties the queue and marks every
//   slot absent with no wake pending. Queue entries are not cleared; only
//   entries below the count are read.
module round_robin_thread_scheduler
    import rrts_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [3:0]      kind,
    input  wire logic [ID_W-1:0] thread_id,
    input  wire logic            attach_sleeping,
    output logic                 done,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      running_id,
    output logic                 running_valid,
    output logic [4:0]           ready_count
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencing of micro-ops and result status
    rrts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    // slot table, wake flags, ready queue, running slot
    rrts_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .thread_id       (thread_id),
        .attach_sleeping (attach_sleeping),
        .stat            (stat),
        .running_id      (running_id),
        .running_valid   (running_valid),
        .ready_count     (ready_count)
    );

endmodule
`default_nettype wire

### tb/sv/tb_round_robin_thread_scheduler.sv
// Testbench for the round-robin thread scheduler: drives scheduler commands,
// predicts each result with a behavioral scheduler model and checks it.
// Depends on rrts_pkg and round_robin_thread_scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_round_robin_thread_scheduler;
    import rrts_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] running_id;
        logic       running_valid;
        logic [4:0] ready_count;
    } sched_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [3:0] kind = '0;
    logic [3:0] thread_id = '0;
    logic       attach_sleeping = 1'b0;
    logic       busy, done, running_valid;
    logic [1:0] status;
    logic [3:0] running_id;
    logic [4:0] ready_count;

    int errors = 0;

    // predicted scheduler state
    logic [3:0] run_id;
    logic       run_on;
    slot_st_t   slot_state [MAX_THREADS];
    logic       wake_flag [MAX_THREADS];
    logic [3:0] run_queue [$];

    sched_result_t expected_results [$];

    always #5 clk = ~clk;

    round_robin_thread_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .thread_id(thread_id), .attach_sleeping(attach_sleeping), .done(done),
        .status(status), .running_id(running_id), .running_valid(running_valid),
        .ready_count(ready_count)
    );

    // queue helpers on the predicted run queue
    function automatic void queue_append(logic [3:0] id);
        if (run_queue.size() < MAX_THREADS)
        begin
            run_queue.insert(run_queue.size(), id);
            slot_state[id] = ST_READY;
        end
    endfunction

    function automatic void queue_drop(logic [3:0] id);
        for (int i = run_queue.size() - 1; i >= 0; i--)
            if (run_queue[i] == id)
                run_queue.delete(i);
    endfunction

    function automatic void run_queue_head();
        if (run_queue.size() > 0)
        begin
            run_id = run_queue[0];
            run_queue.delete(0);
            run_on = 1'b1;
            slot_state[run_id] = ST_RUN;
        end
        else
        begin
            run_id = '0;
            run_on = 1'b0;
        end
    endfunction

    function automatic sched_result_t schedule_step(logic [3:0] k, logic [3:0] t,
                                                    logic slp);
        sched_result_t r;
        logic [1:0] st_code;
        slot_st_t st;
        logic [3:0] nx;
        st_code = RS_OK;
        st = slot_state[t];    // 4-bit id always in range for 16 slots
        case (k)
            K_START:
            begin
                if (run_on)
                    slot_state[run_id] = ST_ABSENT;
                run_on = 1'b0;
                run_id = '0;
                if (run_queue.size() == 0)
                    st_code = RS_FAIL;
                run_queue_head();
            end
            K_BOOT:
                if (st == ST_ABSENT)
                begin
                    if (run_on)
                        slot_state[run_id] = ST_ABSENT;
                    run_id = t;
                    run_on = 1'b1;
                    slot_state[t] = ST_RUN;
                end
            K_ATTACH:
                if (st == ST_ABSENT)
                begin
                    if (slp)
                        slot_state[t] = ST_SLEEP;
                    else
                        queue_append(t);
                end
            K_DETACH:
                if (st == ST_SLEEP)
                    slot_state[t] = ST_ABSENT;
                else if (st == ST_READY)
                begin
                    queue_drop(t);
                    slot_state[t] = ST_ABSENT;
                end
            K_SLEEP:
                if (run_on)
                begin
                    if (wake_flag[run_id])
                    begin
                        wake_flag[run_id] = 1'b0;
                        st_code = RS_CANCEL;
                    end
                    else
                    begin
                        slot_state[run_id] = ST_SLEEP;
                        run_on = 1'b0;
                        run_queue_head();
                    end
                end
            K_WAKE:
                if (st == ST_SLEEP)
                    queue_append(t);
                else
                    wake_flag[t] = 1'b1;
            K_SETRUN:
                if (st == ST_READY)
                begin
                    queue_drop(t);
                    if (run_on)
                        queue_append(run_id);
                    run_id = t;
                    run_on = 1'b1;
                    slot_state[t] = ST_RUN;
                end
            K_SWITCH:
                if (run_queue.size() > 0)
                begin
                    nx = run_queue[0];
                    run_queue.delete(0);
                    if (run_on)
                        queue_append(run_id);
                    run_id = nx;
                    run_on = 1'b1;
                    slot_state[nx] = ST_RUN;
                end
                else
                    st_code = RS_FAIL;
            K_EXIT:
                if (st == ST_RUN && run_on && run_id == t)
                begin
                    slot_state[t] = ST_ABSENT;
                    run_on = 1'b0;
                    run_queue_head();
                end
                else if (st == ST_READY)
                begin
                    queue_drop(t);
                    slot_state[t] = ST_ABSENT;
                end
                else if (st == ST_SLEEP)
                    slot_state[t] = ST_ABSENT;
            default: ;
        endcase
        r.status = st_code;
        r.running_id = run_on ? run_id : 4'd0;
        r.running_valid = run_on;
        r.ready_count = 5'(run_queue.size());
        return r;
    endfunction

    // send one command item after a random gap; gap 0 keeps start high,
    // so start is left high on return and dropped by the next gap or drain
    task automatic issue_command(logic [3:0] k, logic [3:0] t, logic slp,
                                 bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        thread_id <= t;
        attach_sleeping <= slp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.insert(expected_results.size(), schedule_step(k, t, slp));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result checker: one result per strobe
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status=%0d running_id=%0d", status, running_id);
                errors++;
            end
            else
            begin
                e = expected_results[0];
                expected_results.delete(0);
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (running_id !== e.running_id)
                begin
                    $error("running_id expected %0d actual %0d", e.running_id, running_id);
                    errors++;
                end
                if (running_valid !== e.running_valid)
                begin
                    $error("running_valid expected %0d actual %0d",
                           e.running_valid, running_valid);
                    errors++;
                end
                if (ready_count !== e.ready_count)
                begin
                    $error("ready_count expected %0d actual %0d", e.ready_count, ready_count);
                    errors++;
                end
            end
        end
    end

    // directed: every command kind, empty queue fails, wake cancel, bad kinds
    task automatic test_directed();
        issue_command(K_START, 4'd0, 1'b0);          // empty queue: fail
        issue_command(K_SWITCH, 4'd3, 1'b0);         // empty queue: fail
        issue_command(K_SLEEP, 4'd0, 1'b0);          // nothing running
        issue_command(K_BOOT, 4'd0, 1'b0);
        issue_command(K_BOOT, 4'd0, 1'b0);           // already present
        issue_command(K_ATTACH, 4'd15, 1'b0);
        issue_command(K_ATTACH, 4'd5, 1'b1);
        issue_command(K_ATTACH, 4'd10, 1'b0);
        issue_command(K_WAKE, 4'd5, 1'b0);           // sleeping -> queue tail
        issue_command(K_WAKE, 4'd0, 1'b0);           // running: pending flag
        issue_command(K_SLEEP, 4'd0, 1'b0);          // canceled by pending wake
        issue_command(K_SWITCH, 4'd0, 1'b0);
        issue_command(K_SETRUN, 4'd5, 1'b0);
        issue_command(K_SETRUN, 4'd7, 1'b0);         // not queued
        issue_command(K_DETACH, 4'd10, 1'b0, 1);
        issue_command(K_DETACH, 4'd5, 1'b0, 1);      // running: no change
        issue_command(K_WAKE, 4'd12, 1'b0);          // absent slot: flag set
        issue_command(K_SLEEP, 4'd0, 1'b0);
        issue_command(K_EXIT, 4'd5, 1'b0);
        issue_command(K_EXIT, 4'd9, 1'b0);           // absent
        issue_command(4'd9, 4'd1, 1'b1);
        issue_command(4'd15, 4'd15, 1'b1);
        issue_command(K_START, 4'd0, 1'b0);
        drain_results();                             // sender waits for all
    endtask

    // random: every command kind plus random kinds, attach most often, across all slots
    task automatic test_random(int n);
        logic [3:0] k;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: k = K_ATTACH;
                4, 5:       k = K_WAKE;
                6, 7:       k = K_SWITCH;
                8, 9:       k = K_SLEEP;
                10:         k = K_START;
                11:         k = K_BOOT;
                12, 13:     k = K_DETACH;
                14, 15:     k = K_SETRUN;
                16, 17:     k = K_EXIT;
                default:    k = 4'($urandom_range(0, 15));
            endcase
            issue_command(k, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          (i / 100) % 3 == 2);
        end
        drain_results();
    endtask

    initial
    begin
        run_id = '0;
        run_on = 1'b0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            slot_state[i] = ST_ABSENT;
            wake_flag[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(880);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### round_robin_thread_scheduler.f
rtl/rrts_pkg.sv
rtl/rrts_dpath.sv
rtl/rrts_ctrl.sv
rtl/round_robin_thread_scheduler.sv
tb/sv/tb_round_robin_thread_scheduler.sv
